>>> sv/sbmq_pkg.sv
package sbmq_pkg;

    // result codes carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // operation codes carried on the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // fixed field widths of the stream words
    localparam int OP_W     = 1;
    localparam int QID_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

endpackage

>>> sv/sbmq_ram.sv
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/shared_buffer_multi_queue_top.sv
// shared buffer multi queue: QUEUES fifo queues that share one store of SLOTS
// data slots, with unused slots kept on a linked free list
//
// input stream (s_axis): one word per operation. tuser selects the operation
// (push or pop) and the queue, tdata carries the value to push (ignored on pop)
// output stream (m_axis): exactly one word per input word, in order. tdata is
// the popped value (zero unless a pop succeeds), tuser the status code
// (ok, overflow on push with no free slot, underflow on pop of an empty queue)
//
// pipeline: an accepted word passes the registered read of the slot data ram,
// then the output register. throughput: one word per cycle unless the
// receiver stalls; the link, head and tail updates of a word finish at its
// accept edge, so the next word sees them at once
//
// reset (synchronous, active low): every queue empty, free list holds all slots
// in order starting at slot 0, output stream empty. no clearing pass is needed
// receiver stall: the output register and the ram read stage hold their word;
// s_axis_tready stays high while one of the two stages can still take a word
module shared_buffer_multi_queue_top
    import sbmq_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int QUEUES     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [VALUE_W-1:0]              s_axis_tdata,  // [31:0] push_value
    input  logic [OP_W+QID_W-1:0]           s_axis_tuser,  // [0] operation, [2:1] queue_id
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [VALUE_W-1:0]              m_axis_tdata,  // [31:0] pop_value
    output logic [STATUS_W-1:0]             m_axis_tuser   // [1:0] status
);

    localparam int IW  = $clog2(SLOTS);
    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QXW = (QW > QID_W) ? QW : QID_W;

    // slot pointer with a valid bit, invalid means null
    typedef struct packed {
        logic          vld;
        logic [IW-1:0] idx;
    } t_ptr;

    // linked list state
    t_ptr          r_link [SLOTS];
    t_ptr          r_head [QUEUES];
    logic [IW-1:0] r_tail [QUEUES];
    t_ptr          r_free;

    // ram read stage and output register
    logic           r_s1_vld;
    t_status        r_s1_status;
    logic           r_s1_pop_ok;
    logic           r_out_vld;
    t_status        r_out_status;
    logic [VALUE_W-1:0] r_out_data;

    logic                  in_op;
    logic [QID_W-1:0]      in_qid;
    logic [QXW-1:0]        q_ext;
    logic [QW-1:0]         q;
    t_ptr                  hd;
    logic [IW-1:0]         tl;
    logic                  out_free;
    logic                  s1_move;
    logic                  accept;
    logic                  push_ok;
    logic                  pop_ok;
    t_status               in_status;
    logic signed [DATA_WIDTH-1:0] rd_data;
    logic signed [DATA_WIDTH-1:0] wr_data;

    assign in_op  = s_axis_tuser[0];
    assign in_qid = s_axis_tuser[OP_W+QID_W-1:OP_W];

    // queue id reduced modulo QUEUES, at most three subtract steps on 2 bits
    always_comb begin
        q_ext = QXW'(in_qid);
        for (int k = 0; k < 3; k++) begin
            if (q_ext >= QXW'(QUEUES) && QUEUES < (1 << QID_W)) begin
                q_ext = q_ext - QXW'(QUEUES);
            end
        end
    end
    assign q = q_ext[QW-1:0];

    assign hd = r_head[q];
    assign tl = r_tail[q];

    // handshake
    assign out_free      = !r_out_vld || m_axis_tready;
    assign s1_move       = r_s1_vld && out_free;
    assign s_axis_tready = !r_s1_vld || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign push_ok = (in_op == OP_PUSH) && r_free.vld;
    assign pop_ok  = (in_op == OP_POP) && hd.vld;

    always_comb begin
        case (in_op)
            OP_PUSH: in_status = r_free.vld ? ST_OK : ST_OVERFLOW;
            default: in_status = hd.vld ? ST_OK : ST_UNDERFLOW;
        endcase
    end

    // list updates, all at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_link[i].vld <= (i + 1 < SLOTS);
                r_link[i].idx <= IW'(i + 1);
            end
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= '0;
            end
            r_free.vld <= 1'b1;
            r_free.idx <= '0;
        end else if (accept) begin
            if (push_ok) begin
                r_free <= r_link[r_free.idx];
                if (hd.vld) begin
                    r_link[tl].vld <= 1'b1;
                    r_link[tl].idx <= r_free.idx;
                end else begin
                    r_head[q].vld <= 1'b1;
                    r_head[q].idx <= r_free.idx;
                end
                r_link[r_free.idx] <= '0;
            end else if (pop_ok) begin
                r_head[q]     <= r_link[hd.idx];
                r_link[hd.idx] <= r_free;
                r_free.vld    <= 1'b1;
                r_free.idx    <= hd.idx;
            end
        end
    end

    // tail is only read while its queue is not empty
    always_ff @(posedge i_clk) begin
        if (accept && push_ok) begin
            r_tail[q] <= r_free.idx;
        end
    end

    // slot data store: written by a push, read by a pop
    assign wr_data = DATA_WIDTH'(signed'(s_axis_tdata));

    sbmq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && push_ok),
        .i_wr_addr (r_free.idx),
        .i_wr_data (wr_data),
        .i_rd_en   (accept && pop_ok),
        .i_rd_addr (hd.idx),
        .o_rd_data (rd_data)
    );

    // ram read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= in_status;
            r_s1_pop_ok <= pop_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_status;
            // popped word is sign extended from DATA_WIDTH bits
            r_out_data   <= r_s1_pop_ok ? VALUE_W'(rd_data) : '0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // a successful pop always leaves a free slot
    a_pop_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pop_ok |=> r_free.vld)
        else $error("free list empty after pop");

    // a successful push always leaves its queue non-empty
    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && push_ok |=> r_head[$past(q)].vld)
        else $error("queue empty after push");

    // a stalled read stage keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !out_free |=> r_s1_vld && $stable(r_s1_status)
            && $stable(r_s1_pop_ok))
        else $error("read stage lost a word under stall");

    // a failed operation or a push gives a zero value
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && !r_s1_pop_ok |=> r_out_data == '0)
        else $error("nonzero value without a successful pop");

endmodule
